// ----- src/psgi_pkg.sv -----
`timescale 1ns / 1ps

package psgi_pkg;

	localparam int MAX_ORDER = 8;
	localparam int MAX_TRI   = MAX_ORDER * (MAX_ORDER + 1) / 2;
	localparam int ADDR_W    = $clog2(MAX_TRI);
	localparam int CW_W      = $clog2(MAX_ORDER);
	localparam int ORD_W     = 4;
	localparam int DATA_W    = 64;
	localparam int TOL_W     = 32;

	localparam logic [DATA_W-1:0] ONE_Q32 = 64'h0000_0001_0000_0000;
	localparam logic [DATA_W-1:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [DATA_W-1:0] SAT_MIN = 64'h8000_0000_0000_0000;

	// configuration register indexes
	localparam logic REG_ORDER = 1'b0;
	localparam logic REG_TOL   = 1'b1;

	typedef enum logic [1:0] {
		AOP_MUL  = 2'd0,
		AOP_DIV  = 2'd1,
		AOP_SQRT = 2'd2,
		AOP_TOL  = 2'd3
	} aop_t;

	typedef enum logic [3:0] {
		DP_NOP       = 4'd0,
		DP_LOAD_W    = 4'd1,
		DP_LATCH_OPA = 4'd2,
		DP_LATCH_PIV = 4'd3,
		DP_START     = 4'd4,
		DP_W_SUB     = 4'd5,
		DP_W_LOADR   = 4'd6,
		DP_W_ZERO    = 4'd7,
		DP_OUT_C     = 4'd8,
		DP_OUT_ZERO  = 4'd9
	} dp_op_t;

	typedef enum logic [2:0] {
		XS_OPA = 3'd0,
		XS_W   = 3'd1,
		XS_AK  = 3'd2,
		XS_ONE = 3'd3,
		XS_CW  = 3'd4
	} xsel_t;

	typedef enum logic [1:0] {
		YS_CRD = 2'd0,
		YS_OPA = 2'd1,
		YS_PIV = 2'd2
	} ysel_t;

	typedef struct packed {
		dp_op_t            op;
		aop_t              aop;
		xsel_t             xsel;
		ysel_t             ysel;
		logic              a_we;
		logic [ADDR_W-1:0] a_waddr;
		logic [ADDR_W-1:0] a_raddr;
		logic [ADDR_W-1:0] c_raddr;
		logic              c_we;
		logic [ADDR_W-1:0] c_waddr;
		logic              c_wzero;
		logic              cw_we;
		logic [CW_W-1:0]   cw_waddr;
		logic [CW_W-1:0]   cw_raddr;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic w_neg;
		logic w_lt_tol;
		logic w_gt_tol;
		logic opa_zero;
		logic crd_zero;
	} stat_t;

	function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] x);
		return x[DATA_W-1] ? (~x + 64'd1) : x;
	endfunction

	function automatic logic [DATA_W-1:0] pack(input logic neg, input logic [DATA_W-1:0] m);
		logic [DATA_W-1:0] r;
		if (!neg)
			r = m[DATA_W-1] ? SAT_MAX : m;
		else if (m[DATA_W-1])
			r = SAT_MIN;
		else
			r = ~m + 64'd1;
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] sat_sub(input logic [DATA_W-1:0] x,
			input logic [DATA_W-1:0] y);
		logic [DATA_W:0] d;
		logic [DATA_W-1:0] r;
		d = {x[DATA_W-1], x} - {y[DATA_W-1], y};
		if (d[DATA_W] != d[DATA_W-1])
			r = d[DATA_W] ? SAT_MIN : SAT_MAX;
		else
			r = d[DATA_W-1:0];
		return r;
	endfunction

	function automatic logic [ORD_W-1:0] clamp_order(input logic [ORD_W-1:0] o);
		logic [ORD_W-1:0] r;
		if (o == '0)
			r = ORD_W'(1);
		else if (o > ORD_W'(MAX_ORDER))
			r = ORD_W'(MAX_ORDER);
		else
			r = o;
		return r;
	endfunction

	// packed triangle size n(n+1)/2 for n up to the max order
	function automatic logic [ADDR_W:0] tri_count(input logic [ORD_W-1:0] n);
		logic [2*ORD_W:0] p;
		p = ({1'b0, n} * ({1'b0, n} + 5'd1)) >> 1;
		return (ADDR_W + 1)'(p);
	endfunction

endpackage

// ----- src/packed_symmetric_generalized_inverse.sv -----
`timescale 1ns / 1ps
// Generalized inverse of a packed symmetric positive semi-definite matrix, Q31.32.
// Input: pulse start with element while busy is low; elements of the lower
// triangle arrive in row order, n(n+1)/2 of them for order n.
// Output: each inverse element appears for one cycle with done high, in the
// same packed order, with nullity and last on the final one. A matrix that is
// not positive semi-definite gives a single transaction with fault_code and
// last set and a zero element. The receiver cannot stall results.
// Loading stores one element per start pulse. After the last one busy
// rises and the factorisation and back substitution run on one shared
// arithmetic unit for multiplies, divides and square roots, with memory
// access states around each step. An order-8 matrix needs roughly 70
// divides. Each result then takes a read state (ST_O_RD) and a capture
// state (ST_O_CAP). Configuration: cfg_we writes matrix_order (index 0)
// or pivot_tolerance (index 1), which the user must do only while idle;
// the block does not enforce it. Writing the order discards a partial load.
// Reset (arst_n low) returns order 1, tolerance 4, and an empty load.
module packed_symmetric_generalized_inverse (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [63:0]            element,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [psgi_pkg::TOL_W-1:0]    cfg_data,
	output logic                          done,
	output logic signed [63:0]            inverse_element,
	output logic [3:0]                    nullity,
	output logic                          fault_code,
	output logic                          last
);

	psgi_pkg::cmd_t  cmd;
	psgi_pkg::stat_t stat;
	logic [63:0]     inv;

	psgi_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.order_we   (cfg_we && cfg_index == psgi_pkg::REG_ORDER),
		.order_data (cfg_data[3:0]),
		.cmd        (cmd),
		.stat       (stat),
		.done       (done),
		.nullity    (nullity),
		.fault_code (fault_code),
		.last       (last)
	);

	psgi_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.element         (element),
		.tol_we          (cfg_we && cfg_index == psgi_pkg::REG_TOL),
		.tol_data        (cfg_data),
		.inverse_element (inv)
	);

	assign inverse_element = inv;

endmodule

// ----- src/psgi_arith.sv -----
`timescale 1ns / 1ps

module psgi_arith (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  psgi_pkg::aop_t                op,
	input  logic [psgi_pkg::DATA_W-1:0]   x,
	input  logic [psgi_pkg::DATA_W-1:0]   y,
	input  logic [psgi_pkg::TOL_W-1:0]    tol,
	output logic                          done,
	output logic [psgi_pkg::DATA_W-1:0]   result
);

	typedef enum logic [3:0] {
		AS_IDLE = 4'b0001,
		AS_MUL  = 4'b0010,
		AS_DIV  = 4'b0100,
		AS_SQRT = 4'b1000
	} ast_t;

	ast_t         st_q;
	logic [7:0]   cnt_q;
	logic [63:0]  ma_q, mb_q;
	logic         neg_q, tolm_q, over_q;
	logic [63:0]  p_q;
	logic [127:0] acc_q;
	logic [127:0] dvd_q;
	logic [63:0]  rem_q, quo_q;
	logic [95:0]  sv_q;
	logic [51:0]  srem_q;
	logic [47:0]  root_q;
	logic [63:0]  res_q;
	logic         done_q;

	logic [31:0]  ha, hb;
	logic [64:0]  r2;
	logic [51:0]  s2, trial;

	always_comb begin
		case (cnt_q[1:0])
			2'd0: begin ha = ma_q[31:0];  hb = mb_q[31:0];  end
			2'd1: begin ha = ma_q[31:0];  hb = mb_q[63:32]; end
			2'd2: begin ha = ma_q[63:32]; hb = mb_q[31:0];  end
			default: begin ha = ma_q[63:32]; hb = mb_q[63:32]; end
		endcase
		r2    = {rem_q, dvd_q[127]};
		s2    = {srem_q[49:0], sv_q[95:94]};
		trial = {2'b00, root_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= AS_IDLE;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				AS_IDLE: begin
					cnt_q <= '0;
					if (start) begin
						case (op)
							psgi_pkg::AOP_MUL, psgi_pkg::AOP_TOL: begin
								ma_q   <= psgi_pkg::mag(x);
								mb_q   <= (op == psgi_pkg::AOP_TOL) ? {32'd0, tol}
									: psgi_pkg::mag(y);
								neg_q  <= x[63] ^ y[63];
								tolm_q <= (op == psgi_pkg::AOP_TOL);
								st_q   <= AS_MUL;
							end
							psgi_pkg::AOP_DIV: begin
								mb_q   <= psgi_pkg::mag(y);
								dvd_q  <= {32'd0, psgi_pkg::mag(x), 32'd0};
								rem_q  <= '0;
								quo_q  <= '0;
								over_q <= 1'b0;
								neg_q  <= x[63] ^ y[63];
								if (y == '0) begin
									res_q  <= '0;
									done_q <= 1'b1;
								end else begin
									st_q <= AS_DIV;
								end
							end
							default: begin
								sv_q   <= {x, 32'd0};
								srem_q <= '0;
								root_q <= '0;
								if (x[63] || x == '0) begin
									res_q  <= '0;
									done_q <= 1'b1;
								end else begin
									st_q <= AS_SQRT;
								end
							end
						endcase
					end
				end
				AS_MUL: begin
					cnt_q <= cnt_q + 8'd1;
					p_q   <= ha * hb;
					case (cnt_q)
						8'd1: acc_q <= {64'd0, p_q};
						8'd2, 8'd3: acc_q <= acc_q + {32'd0, p_q, 32'd0};
						8'd4: acc_q <= acc_q + {p_q, 64'd0};
						8'd5: begin
							if (tolm_q)
								res_q <= acc_q[95:32];
							else if (acc_q[127:96] != '0)
								res_q <= neg_q ? psgi_pkg::SAT_MIN : psgi_pkg::SAT_MAX;
							else
								res_q <= psgi_pkg::pack(neg_q, acc_q[95:32]);
							done_q <= 1'b1;
							st_q   <= AS_IDLE;
						end
						default: ;
					endcase
				end
				AS_DIV: begin
					cnt_q <= cnt_q + 8'd1;
					if (cnt_q == 8'd128) begin
						res_q  <= over_q ? (neg_q ? psgi_pkg::SAT_MIN : psgi_pkg::SAT_MAX)
							: psgi_pkg::pack(neg_q, quo_q);
						done_q <= 1'b1;
						st_q   <= AS_IDLE;
					end else begin
						dvd_q <= {dvd_q[126:0], 1'b0};
						if (quo_q[63])
							over_q <= 1'b1;
						if (r2 >= {1'b0, mb_q}) begin
							rem_q <= 64'(r2 - {1'b0, mb_q});
							quo_q <= {quo_q[62:0], 1'b1};
						end else begin
							rem_q <= r2[63:0];
							quo_q <= {quo_q[62:0], 1'b0};
						end
					end
				end
				AS_SQRT: begin
					cnt_q <= cnt_q + 8'd1;
					if (cnt_q == 8'd48) begin
						res_q  <= {16'd0, root_q};
						done_q <= 1'b1;
						st_q   <= AS_IDLE;
					end else begin
						sv_q <= {sv_q[93:0], 2'b00};
						if (s2 >= trial) begin
							srem_q <= s2 - trial;
							root_q <= {root_q[46:0], 1'b1};
						end else begin
							srem_q <= s2;
							root_q <= {root_q[46:0], 1'b0};
						end
					end
				end
				default: st_q <= AS_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// ----- src/psgi_datapath.sv -----
`timescale 1ns / 1ps

module psgi_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  psgi_pkg::cmd_t                cmd,
	output psgi_pkg::stat_t               stat,
	input  logic [psgi_pkg::DATA_W-1:0]   element,
	input  logic                          tol_we,
	input  logic [psgi_pkg::TOL_W-1:0]    tol_data,
	output logic [psgi_pkg::DATA_W-1:0]   inverse_element
);

	logic [63:0] a_mem [psgi_pkg::MAX_TRI];
	logic [63:0] c_mem [psgi_pkg::MAX_TRI];
	logic [63:0] cw_mem [psgi_pkg::MAX_ORDER];

	logic [63:0] a_rd_q, c_rd_q, cw_rd_q;
	logic [63:0] w_q, ak_q, opa_q, piv_q, out_q;
	logic [31:0] tol_q;
	logic [63:0] ax, ay, ar, magw;
	logic        adone;

	always_ff @(posedge clk) begin
		if (cmd.a_we)
			a_mem[cmd.a_waddr] <= element;
		a_rd_q <= a_mem[cmd.a_raddr];
		if (cmd.c_we)
			c_mem[cmd.c_waddr] <= cmd.c_wzero ? 64'd0 : ar;
		c_rd_q <= c_mem[cmd.c_raddr];
		if (cmd.cw_we)
			cw_mem[cmd.cw_waddr] <= c_rd_q;
		cw_rd_q <= cw_mem[cmd.cw_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tol_q <= 32'd4;
		else if (tol_we)
			tol_q <= tol_data;
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			psgi_pkg::DP_LOAD_W: begin
				w_q  <= a_rd_q;
				ak_q <= a_rd_q;
			end
			psgi_pkg::DP_LATCH_OPA: opa_q <= c_rd_q;
			psgi_pkg::DP_LATCH_PIV: piv_q <= cw_rd_q;
			psgi_pkg::DP_W_SUB:     w_q   <= psgi_pkg::sat_sub(w_q, ar);
			psgi_pkg::DP_W_LOADR:   w_q   <= ar;
			psgi_pkg::DP_W_ZERO:    w_q   <= '0;
			psgi_pkg::DP_OUT_C:     out_q <= c_rd_q;
			psgi_pkg::DP_OUT_ZERO:  out_q <= '0;
			default: ;
		endcase
	end

	always_comb begin
		case (cmd.xsel)
			psgi_pkg::XS_OPA: ax = opa_q;
			psgi_pkg::XS_W:   ax = w_q;
			psgi_pkg::XS_AK:  ax = ak_q;
			psgi_pkg::XS_ONE: ax = psgi_pkg::ONE_Q32;
			psgi_pkg::XS_CW:  ax = cw_rd_q;
			default:          ax = w_q;
		endcase
		case (cmd.ysel)
			psgi_pkg::YS_CRD: ay = c_rd_q;
			psgi_pkg::YS_OPA: ay = opa_q;
			psgi_pkg::YS_PIV: ay = piv_q;
			default:          ay = c_rd_q;
		endcase
	end

	psgi_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.op == psgi_pkg::DP_START),
		.op     (cmd.aop),
		.x      (ax),
		.y      (ay),
		.tol    (tol_q),
		.done   (adone),
		.result (ar)
	);

	assign magw = psgi_pkg::mag(w_q);

	always_comb begin
		stat.done     = adone;
		stat.w_neg    = w_q[63];
		stat.w_lt_tol = magw < ar;
		stat.w_gt_tol = magw > ar;
		stat.opa_zero = (opa_q == '0);
		stat.crd_zero = (c_rd_q == '0);
	end

	assign inverse_element = out_q;

endmodule

// ----- src/psgi_ctrl.sv -----
`timescale 1ns / 1ps

module psgi_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        order_we,
	input  logic [psgi_pkg::ORD_W-1:0]  order_data,
	output psgi_pkg::cmd_t              cmd,
	input  psgi_pkg::stat_t             stat,
	output logic                        done,
	output logic [psgi_pkg::ORD_W-1:0]  nullity,
	output logic                        fault_code,
	output logic                        last
);

	localparam int AW = psgi_pkg::ADDR_W;

	typedef enum logic [35:0] {
		ST_IDLE  = 36'h1 << 0,
		ST_F_COL = 36'h1 << 1,
		ST_F_ROW = 36'h1 << 2,
		ST_F_WLD = 36'h1 << 3,
		ST_F_RD1 = 36'h1 << 4,
		ST_F_RD2 = 36'h1 << 5,
		ST_F_MS  = 36'h1 << 6,
		ST_F_MW  = 36'h1 << 7,
		ST_F_BRK = 36'h1 << 8,
		ST_F_OFF = 36'h1 << 9,
		ST_F_OTW = 36'h1 << 10,
		ST_F_DW  = 36'h1 << 11,
		ST_F_NXR = 36'h1 << 12,
		ST_F_TLS = 36'h1 << 13,
		ST_F_TW  = 36'h1 << 14,
		ST_F_SW  = 36'h1 << 15,
		ST_F_NXC = 36'h1 << 16,
		ST_FAULT = 36'h1 << 17,
		ST_I_INI = 36'h1 << 18,
		ST_I_ROW = 36'h1 << 19,
		ST_I_CHK = 36'h1 << 20,
		ST_I_ZR  = 36'h1 << 21,
		ST_I_CWR = 36'h1 << 22,
		ST_I_CWW = 36'h1 << 23,
		ST_I_PIV = 36'h1 << 24,
		ST_I_PVL = 36'h1 << 25,
		ST_I_LP  = 36'h1 << 26,
		ST_I_DW1 = 36'h1 << 27,
		ST_I_INN = 36'h1 << 28,
		ST_I_IL  = 36'h1 << 29,
		ST_I_IMW = 36'h1 << 30,
		ST_I_FS  = 36'h1 << 31,
		ST_I_FW  = 36'h1 << 32,
		ST_I_NXR = 36'h1 << 33,
		ST_O_RD  = 36'h1 << 34,
		ST_O_CAP = 36'h1 << 35
	} st_t;

	st_t          state_q, state_d;
	logic [3:0]   order_q, n;
	logic [AW:0]  need;
	logic [AW-1:0] lc_q;
	logic [AW:0]  k_q, m_q, j_q, ndiag_q, jcol_q, mdiag_q;
	logic [AW:0]  l_q, nl;
	logic [3:0]   icol_q, irow_q, i_q, nul_q, zp_q;
	logic         done_q, last_q, fault_q;

	assign n    = psgi_pkg::clamp_order(order_q);
	assign need = psgi_pkg::tri_count(n);
	assign nl   = l_q - 7'd1;

	function automatic logic [AW-1:0] a0(input logic [AW:0] v);
		return AW'(v - 7'd1);
	endfunction

	always_comb begin
		cmd       = '0;
		cmd.op    = psgi_pkg::DP_NOP;
		cmd.aop   = psgi_pkg::AOP_MUL;
		cmd.xsel  = psgi_pkg::XS_W;
		cmd.ysel  = psgi_pkg::YS_CRD;
		state_d   = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.a_we    = 1'b1;
					cmd.a_waddr = lc_q;
					if ({1'b0, lc_q} + 7'd1 == need)
						state_d = ST_F_COL;
				end
			end
			ST_F_COL: state_d = ST_F_ROW;
			ST_F_ROW: begin
				cmd.a_raddr = AW'(k_q);
				state_d     = ST_F_WLD;
			end
			ST_F_WLD: begin
				cmd.op  = psgi_pkg::DP_LOAD_W;
				state_d = ST_F_RD1;
			end
			ST_F_RD1: begin
				cmd.c_raddr = AW'(l_q);
				state_d     = (i_q == irow_q) ? ST_F_BRK : ST_F_RD2;
			end
			ST_F_RD2: begin
				cmd.c_raddr = a0(m_q);
				cmd.op      = psgi_pkg::DP_LATCH_OPA;
				state_d     = ST_F_MS;
			end
			ST_F_MS: begin
				cmd.op   = psgi_pkg::DP_START;
				cmd.aop  = psgi_pkg::AOP_MUL;
				cmd.xsel = psgi_pkg::XS_OPA;
				cmd.ysel = psgi_pkg::YS_CRD;
				state_d  = ST_F_MW;
			end
			ST_F_MW: begin
				if (stat.done) begin
					cmd.op  = psgi_pkg::DP_W_SUB;
					state_d = ST_F_RD1;
				end
			end
			ST_F_BRK: begin
				cmd.op  = psgi_pkg::DP_LATCH_OPA;
				state_d = (irow_q == icol_q) ? ST_F_TLS : ST_F_OFF;
			end
			ST_F_OFF: begin
				cmd.op = psgi_pkg::DP_START;
				if (stat.opa_zero) begin
					cmd.c_we    = 1'b1;
					cmd.c_waddr = a0(k_q);
					cmd.c_wzero = 1'b1;
					cmd.aop     = psgi_pkg::AOP_TOL;
					cmd.xsel    = psgi_pkg::XS_AK;
					state_d     = ST_F_OTW;
				end else begin
					cmd.aop  = psgi_pkg::AOP_DIV;
					cmd.xsel = psgi_pkg::XS_W;
					cmd.ysel = psgi_pkg::YS_OPA;
					state_d  = ST_F_DW;
				end
			end
			ST_F_OTW: begin
				if (stat.done)
					state_d = stat.w_gt_tol ? ST_FAULT : ST_F_NXR;
			end
			ST_F_DW: begin
				if (stat.done) begin
					cmd.c_we    = 1'b1;
					cmd.c_waddr = a0(k_q);
					state_d     = ST_F_NXR;
				end
			end
			ST_F_NXR: state_d = ST_F_ROW;
			ST_F_TLS: begin
				cmd.op   = psgi_pkg::DP_START;
				cmd.aop  = psgi_pkg::AOP_TOL;
				cmd.xsel = psgi_pkg::XS_AK;
				state_d  = ST_F_TW;
			end
			ST_F_TW: begin
				if (stat.done) begin
					if (stat.w_lt_tol) begin
						cmd.c_we    = 1'b1;
						cmd.c_waddr = a0(k_q);
						cmd.c_wzero = 1'b1;
						state_d     = ST_F_NXC;
					end else if (stat.w_neg) begin
						state_d = ST_FAULT;
					end else begin
						cmd.op   = psgi_pkg::DP_START;
						cmd.aop  = psgi_pkg::AOP_SQRT;
						cmd.xsel = psgi_pkg::XS_W;
						state_d  = ST_F_SW;
					end
				end
			end
			ST_F_SW: begin
				if (stat.done) begin
					cmd.c_we    = 1'b1;
					cmd.c_waddr = a0(k_q);
					state_d     = ST_F_NXC;
				end
			end
			ST_F_NXC: state_d = (icol_q == n) ? ST_I_INI : ST_F_COL;
			ST_FAULT: begin
				cmd.op  = psgi_pkg::DP_OUT_ZERO;
				state_d = ST_IDLE;
			end
			ST_I_INI: state_d = ST_I_ROW;
			ST_I_ROW: begin
				cmd.c_raddr = a0(ndiag_q);
				state_d     = ST_I_CHK;
			end
			ST_I_CHK: state_d = stat.crd_zero ? ST_I_ZR : ST_I_CWR;
			ST_I_ZR: begin
				cmd.c_we    = 1'b1;
				cmd.c_waddr = a0(l_q);
				cmd.c_wzero = 1'b1;
				state_d     = (i_q == n) ? ST_I_NXR : ST_I_ZR;
			end
			ST_I_CWR: begin
				cmd.c_raddr = a0(l_q);
				state_d     = ST_I_CWW;
			end
			ST_I_CWW: begin
				cmd.cw_we    = 1'b1;
				cmd.cw_waddr = psgi_pkg::CW_W'(i_q - 4'd1);
				state_d      = (i_q == n) ? ST_I_PIV : ST_I_CWR;
			end
			ST_I_PIV: begin
				cmd.cw_raddr = psgi_pkg::CW_W'(irow_q - 4'd1);
				state_d      = ST_I_PVL;
			end
			ST_I_PVL: begin
				cmd.op  = psgi_pkg::DP_LATCH_PIV;
				state_d = ST_I_LP;
			end
			ST_I_LP: begin
				if (icol_q == irow_q) begin
					cmd.op   = psgi_pkg::DP_START;
					cmd.aop  = psgi_pkg::AOP_DIV;
					cmd.xsel = psgi_pkg::XS_ONE;
					cmd.ysel = psgi_pkg::YS_PIV;
					state_d  = ST_I_DW1;
				end else begin
					cmd.op  = psgi_pkg::DP_W_ZERO;
					state_d = ST_I_INN;
				end
			end
			ST_I_DW1: begin
				if (stat.done) begin
					cmd.op  = psgi_pkg::DP_W_LOADR;
					state_d = ST_I_INN;
				end
			end
			ST_I_INN: begin
				if (k_q != {3'd0, irow_q}) begin
					cmd.cw_raddr = psgi_pkg::CW_W'(k_q - 7'd1);
					cmd.c_raddr  = a0(l_q);
					state_d      = ST_I_IL;
				end else begin
					state_d = ST_I_FS;
				end
			end
			ST_I_IL: begin
				cmd.op   = psgi_pkg::DP_START;
				cmd.aop  = psgi_pkg::AOP_MUL;
				cmd.xsel = psgi_pkg::XS_CW;
				cmd.ysel = psgi_pkg::YS_CRD;
				state_d  = ST_I_IMW;
			end
			ST_I_IMW: begin
				if (stat.done) begin
					cmd.op  = psgi_pkg::DP_W_SUB;
					state_d = ST_I_INN;
				end
			end
			ST_I_FS: begin
				cmd.op   = psgi_pkg::DP_START;
				cmd.aop  = psgi_pkg::AOP_DIV;
				cmd.xsel = psgi_pkg::XS_W;
				cmd.ysel = psgi_pkg::YS_PIV;
				state_d  = ST_I_FW;
			end
			ST_I_FW: begin
				if (stat.done) begin
					cmd.c_we    = 1'b1;
					cmd.c_waddr = a0(l_q);
					state_d     = (icol_q == irow_q || icol_q <= 4'd1) ? ST_I_NXR : ST_I_LP;
				end
			end
			ST_I_NXR: state_d = (irow_q == 4'd1) ? ST_O_RD : ST_I_ROW;
			ST_O_RD: begin
				cmd.c_raddr = a0(k_q);
				state_d     = ST_O_CAP;
			end
			ST_O_CAP: begin
				cmd.op  = psgi_pkg::DP_OUT_C;
				state_d = (k_q == need) ? ST_IDLE : ST_O_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			order_q <= 4'd1;
			lc_q    <= '0;
			zp_q    <= '0;
			nul_q   <= '0;
			done_q  <= 1'b0;
			last_q  <= 1'b0;
			fault_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			last_q  <= 1'b0;
			fault_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if ({1'b0, lc_q} + 7'd1 == need) begin
							lc_q   <= '0;
							icol_q <= 4'd1;
							j_q    <= 7'd1;
							k_q    <= '0;
							nul_q  <= '0;
						end else begin
							lc_q <= lc_q + 6'd1;
						end
					end
				end
				ST_F_COL: begin
					l_q    <= '0;
					irow_q <= 4'd1;
				end
				ST_F_ROW: begin
					m_q <= j_q;
					k_q <= k_q + 7'd1;
					i_q <= 4'd1;
				end
				ST_F_RD1: l_q <= l_q + 7'd1;
				ST_F_MW: begin
					if (stat.done) begin
						m_q <= m_q + 7'd1;
						i_q <= i_q + 4'd1;
					end
				end
				ST_F_TW: begin
					if (stat.done && stat.w_lt_tol)
						nul_q <= nul_q + 4'd1;
				end
				ST_F_NXR: irow_q <= irow_q + 4'd1;
				ST_F_NXC: begin
					j_q    <= j_q + {3'd0, icol_q};
					icol_q <= icol_q + 4'd1;
				end
				ST_FAULT: begin
					zp_q    <= nul_q;
					done_q  <= 1'b1;
					last_q  <= 1'b1;
					fault_q <= 1'b1;
				end
				ST_I_INI: begin
					irow_q  <= n;
					ndiag_q <= need;
					zp_q    <= nul_q;
				end
				ST_I_ROW: l_q <= ndiag_q;
				ST_I_CHK: begin
					i_q     <= irow_q;
					icol_q  <= n;
					jcol_q  <= need;
					mdiag_q <= need;
				end
				ST_I_ZR, ST_I_CWW: begin
					l_q <= l_q + {3'd0, i_q};
					i_q <= i_q + 4'd1;
				end
				ST_I_LP: begin
					k_q <= {3'd0, n};
					l_q <= jcol_q;
				end
				ST_I_IMW: begin
					if (stat.done) begin
						k_q <= k_q - 7'd1;
						// step back along the row, jumping to the next column below the diagonal
						l_q <= (nl > mdiag_q) ? nl - k_q + 7'd2 : nl;
					end
				end
				ST_I_FW: begin
					if (stat.done) begin
						mdiag_q <= mdiag_q - {3'd0, icol_q};
						icol_q  <= icol_q - 4'd1;
						jcol_q  <= jcol_q - 7'd1;
					end
				end
				ST_I_NXR: begin
					ndiag_q <= ndiag_q - {3'd0, irow_q};
					irow_q  <= irow_q - 4'd1;
					k_q     <= 7'd1;
				end
				ST_O_CAP: begin
					done_q <= 1'b1;
					last_q <= (k_q == need);
					k_q    <= k_q + 7'd1;
				end
				default: ;
			endcase
			if (order_we) begin
				order_q <= order_data;
				lc_q    <= '0;
			end
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign last       = last_q;
	assign fault_code = fault_q;
	assign nullity    = zp_q;

endmodule

// ----- src/psgi_checker.sv -----
`timescale 1ns / 1ps

module psgi_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [63:0] inverse_element,
	input logic        fault_code,
	input logic        last
);

	a_last_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> done) else $error("last without result strobe");

	a_fault_form: assert property (@(posedge clk) disable iff (!arst_n)
		fault_code |-> (done && last && inverse_element == 64'd0))
		else $error("malformed fault transaction");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(done && last) |=> !done) else $error("result after last transaction");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start)) else $error("busy rose without start");

endmodule

bind packed_symmetric_generalized_inverse psgi_checker u_psgi_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.done            (done),
	.inverse_element (inverse_element),
	.fault_code      (fault_code),
	.last            (last)
);
